/* rtl/core/calendar_date_shift_defines.svh */
// Assertion macros for the date shift controller.
`ifndef CALENDAR_DATE_SHIFT_DEFINES_SVH
`define CALENDAR_DATE_SHIFT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/cds_pkg.sv */
package cds_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int WDAY_W  = 3;
    localparam int SHIFT_W = 16;

    // Working year carries sign and headroom beyond the field range.
    localparam int YWORK_W = YEAR_W + 2;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd0;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd5;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd8;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd10;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd11;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd16383;

    // floor(y / 25) == (y * 5243) >> 17 for every 14-bit y.
    localparam int          RECIP_SHIFT = 17;
    localparam logic [12:0] RECIP_25    = 13'd5243;
    localparam int          Q25_W       = 10;
    localparam logic [4:0]  MOD25_TOP   = 5'd24;

    // Flipping the sign bit of the shift adds 32768, which is 1 modulo 7; this
    // bias brings the sum back to weekday plus shift modulo 7.
    localparam logic [16:0] WDAY_BIAS = 17'd6;

    typedef struct packed {
        logic load;
        logic prep;
        logic first;
        logic step;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic done;
    } stat_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] days;
        case (month)
            MON_APR, MON_JUN, MON_SEP, MON_NOV: days = 5'd30;
            MON_FEB:                            days = leap ? 5'd29 : 5'd28;
            default:                            days = 5'd31;
        endcase
        return days;
    endfunction

    // Remainder by 7 using 8 == 1 (mod 7): fold the octal digits together.
    function automatic logic [WDAY_W-1:0] mod7(input logic [16:0] v);
        logic [5:0] f1;
        logic [3:0] f2;
        logic [3:0] f3;
        logic [WDAY_W-1:0] r;
        f1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
           + 6'(v[14:12]) + 6'(v[16:15]);
        f2 = 4'(f1[2:0]) + 4'(f1[5:3]);
        f3 = 4'(f2[2:0]) + 4'(f2[3]);
        r  = (f3 >= 4'd7) ? 3'(f3 - 4'd7) : f3[2:0];
        return r;
    endfunction

endpackage

/* rtl/core/cds_ctrl.sv */
module cds_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output cds_pkg::cmd_t cmd,
    input  cds_pkg::stat_t stat
);
    import cds_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PREP  = 5'b00010,
        ST_FIRST = 5'b00100,
        ST_STEP  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                cmd.first  = 1'b1;
                state_next = stat.done ? ST_DONE : ST_STEP;
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                if (stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.capture = slot_free;
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`include "calendar_date_shift_defines.svh"

    `CDS_ASSERT_NEXT(a_accept_to_prep, s_tvalid && s_tready, state_reg == ST_PREP, "accepted item did not start")
    `CDS_ASSERT_NOW(a_capture_free, cmd.capture, !out_valid_reg || m_tready, "result overwritten before taken")
    `CDS_ASSERT_NEXT(a_capture_valid, cmd.capture, out_valid_reg && state_reg == ST_IDLE, "captured result not shown")
    `CDS_ASSERT_NEXT(a_walk_holds, cmd.step && !stat.done, state_reg == ST_STEP, "month walk left early")

endmodule

/* rtl/core/cds_dpath.sv */
module cds_dpath (
    input  logic                                clk,
    input  cds_pkg::cmd_t                       cmd,
    output cds_pkg::stat_t                      stat,
    input  logic        [cds_pkg::DAY_W-1:0]    day_of_month,
    input  logic        [cds_pkg::MONTH_W-1:0]  month_index,
    input  logic        [cds_pkg::YEAR_W-1:0]   year_value,
    input  logic        [cds_pkg::WDAY_W-1:0]   weekday_index,
    input  logic signed [cds_pkg::SHIFT_W-1:0]  shift_days,
    output logic        [cds_pkg::DAY_W-1:0]    new_day,
    output logic        [cds_pkg::MONTH_W-1:0]  new_month,
    output logic        [cds_pkg::YEAR_W-1:0]   new_year,
    output logic        [cds_pkg::WDAY_W-1:0]   new_weekday,
    output logic                                year_overflow
);
    import cds_pkg::*;

    logic        [DAY_W-1:0]   day_reg, day_next;
    logic        [MONTH_W-1:0] month_reg, month_next;
    logic signed [YWORK_W-1:0] year_reg, year_next;
    logic        [SHIFT_W-1:0] x_reg, x_next;
    logic        [Q25_W-1:0]   q_reg, q_next;
    logic        [4:0]         mod25_reg, mod25_next;
    logic                      fwd_reg, fwd_next;
    logic                      zero_reg, zero_next;
    logic        [WDAY_W-1:0]  wday_reg, wday_next;
    logic        [DAY_W-1:0]   oday_reg, oday_next;
    logic        [MONTH_W-1:0] omonth_reg, omonth_next;
    logic        [YEAR_W-1:0]  oyear_reg, oyear_next;
    logic        [WDAY_W-1:0]  owday_reg, owday_next;
    logic                      oovf_reg, oovf_next;

    logic        [26:0]        prod;
    logic        [YEAR_W:0]    q_times_25;
    logic                      leap;
    logic        [DAY_W-1:0]   md;
    logic                      fwd_cross;
    logic                      first_done;
    logic                      step_done;
    logic        [16:0]        fwd_rest;
    logic        [16:0]        wsum;

    assign prod = 27'(year_value) * 27'(RECIP_25);
    assign wsum = 17'(weekday_index) + 17'({~shift_days[SHIFT_W-1], shift_days[SHIFT_W-2:0]})
                + WDAY_BIAS;

    assign q_times_25 = 15'({q_reg, 4'b0000}) + 15'({q_reg, 3'b000}) + 15'(q_reg);

    // Leap: divisible by 4 and not by 100 (25 with 4), or by 400 (25 with 16).
    assign leap = (year_reg[1:0] == 2'b00) && ((mod25_reg != 5'd0) || (year_reg[3:0] == 4'd0));
    assign md   = month_days(month_reg, leap);

    // A day beyond the month length always leaves the month going forward.
    assign fwd_cross  = (day_reg > md) || (x_reg > 16'(md - day_reg));
    assign fwd_rest   = 17'(x_reg) + 17'(day_reg) - 17'(md);
    assign first_done = zero_reg || (fwd_reg ? !fwd_cross : (x_reg < 16'(day_reg)));
    assign step_done  = fwd_reg ? (x_reg <= 16'(md)) : (x_reg < 16'(md));
    assign stat.done  = cmd.first ? first_done : step_done;

    always_comb
    begin
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        x_next      = x_reg;
        q_next      = q_reg;
        mod25_next  = mod25_reg;
        fwd_next    = fwd_reg;
        zero_next   = zero_reg;
        wday_next   = wday_reg;
        oday_next   = oday_reg;
        omonth_next = omonth_reg;
        oyear_next  = oyear_reg;
        owday_next  = owday_reg;
        oovf_next   = oovf_reg;

        if (cmd.load)
        begin
            day_next   = day_of_month;
            month_next = (month_index > MON_DEC) ? MON_DEC : month_index;
            year_next  = YWORK_W'(year_value);
            x_next     = shift_days[SHIFT_W-1] ? (~shift_days + 16'd1) : shift_days;
            fwd_next   = !shift_days[SHIFT_W-1] && (shift_days != '0);
            zero_next  = (shift_days == '0);
            q_next     = prod[RECIP_SHIFT +: Q25_W];
            wday_next  = mod7(wsum);
        end

        if (cmd.prep)
        begin
            mod25_next = 5'(15'(year_reg[YEAR_W-1:0]) - q_times_25);
        end

        if ((cmd.first || cmd.step) && !zero_reg)
        begin
            if (stat.done)
            begin
                if (cmd.first)
                begin
                    day_next = fwd_reg ? 5'(day_reg + x_reg[DAY_W-1:0])
                                       : 5'(day_reg - x_reg[DAY_W-1:0]);
                end
                else
                begin
                    day_next = fwd_reg ? x_reg[DAY_W-1:0] : 5'(md - x_reg[DAY_W-1:0]);
                end
            end
            else if (fwd_reg)
            begin
                x_next = cmd.first ? fwd_rest[SHIFT_W-1:0] : 16'(x_reg - 16'(md));
                if (month_reg == MON_DEC)
                begin
                    month_next = MON_JAN;
                    year_next  = year_reg + 16'sd1;
                    mod25_next = (mod25_reg == MOD25_TOP) ? 5'd0 : 5'(mod25_reg + 5'd1);
                end
                else
                begin
                    month_next = 4'(month_reg + 4'd1);
                end
            end
            else
            begin
                x_next = cmd.first ? 16'(x_reg - 16'(day_reg)) : 16'(x_reg - 16'(md));
                if (month_reg == MON_JAN)
                begin
                    month_next = MON_DEC;
                    year_next  = year_reg - 16'sd1;
                    mod25_next = (mod25_reg == 5'd0) ? MOD25_TOP : 5'(mod25_reg - 5'd1);
                end
                else
                begin
                    month_next = 4'(month_reg - 4'd1);
                end
            end
        end

        if (cmd.capture)
        begin
            oday_next   = day_reg;
            omonth_next = month_reg;
            owday_next  = wday_reg;
            if (year_reg < 0)
            begin
                oyear_next = '0;
                oovf_next  = 1'b1;
            end
            else if (year_reg > $signed(YWORK_W'(YEAR_MAX)))
            begin
                oyear_next = YEAR_MAX;
                oovf_next  = 1'b1;
            end
            else
            begin
                oyear_next = year_reg[YEAR_W-1:0];
                oovf_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg    <= day_next;
        month_reg  <= month_next;
        year_reg   <= year_next;
        x_reg      <= x_next;
        q_reg      <= q_next;
        mod25_reg  <= mod25_next;
        fwd_reg    <= fwd_next;
        zero_reg   <= zero_next;
        wday_reg   <= wday_next;
        oday_reg   <= oday_next;
        omonth_reg <= omonth_next;
        oyear_reg  <= oyear_next;
        owday_reg  <= owday_next;
        oovf_reg   <= oovf_next;
    end

    assign new_day       = oday_reg;
    assign new_month     = omonth_reg;
    assign new_year      = oyear_reg;
    assign new_weekday   = owday_reg;
    assign year_overflow = oovf_reg;

endmodule

/* rtl/core/calendar_date_shift.sv */
// Moves a Gregorian date and its weekday by a signed day count. One item
// passes through load, prep, a first step, one walk step per month boundary
// that the shift crosses, and capture, since the date is walked one month per
// cycle through a single month-length unit. A new item is taken once the
// walk has finished and its result is captured, even while that result still
// waits in the output register. A year leaving 0..16383 is saturated and
// flagged in year_overflow.
module calendar_date_shift (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // day_of_month[4:0], month_index[8:5], year_value[22:9],
    // weekday_index[25:23], shift_days[41:26], zero fill above
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // new_day[4:0], new_month[8:5], new_year[22:9], new_weekday[25:23],
    // year_overflow[26], zero fill above
    output logic [31:0] m_tdata
);
    import cds_pkg::*;

    cmd_t                      cmd;
    stat_t                     stat;
    logic        [DAY_W-1:0]   new_day;
    logic        [MONTH_W-1:0] new_month;
    logic        [YEAR_W-1:0]  new_year;
    logic        [WDAY_W-1:0]  new_weekday;
    logic                      year_overflow;

    cds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    cds_dpath u_dpath (
        .clk           (clk),
        .cmd           (cmd),
        .stat          (stat),
        .day_of_month  (s_tdata[4:0]),
        .month_index   (s_tdata[8:5]),
        .year_value    (s_tdata[22:9]),
        .weekday_index (s_tdata[25:23]),
        .shift_days    ($signed(s_tdata[41:26])),
        .new_day       (new_day),
        .new_month     (new_month),
        .new_year      (new_year),
        .new_weekday   (new_weekday),
        .year_overflow (year_overflow)
    );

    assign m_tdata = {5'b00000, year_overflow, new_weekday, new_year, new_month, new_day};

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

    import cds_pkg::*;

    localparam int RANDOM_ITEMS   = 520;
    localparam int HOLD_CYCLES    = 2500;
    localparam int WATCHDOG_LIMIT = 20000;

    // Packed so that the first declared field lands in the highest bits.
    typedef struct packed {
        logic signed [SHIFT_W-1:0] shift;
        logic [WDAY_W-1:0]         wday;
        logic [YEAR_W-1:0]         year;
        logic [MONTH_W-1:0]        month;
        logic [DAY_W-1:0]          day;
    } date_item_t;

    typedef struct packed {
        logic                ovf;
        logic [WDAY_W-1:0]   wday;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } shifted_t;

    typedef struct packed {
        date_item_t stim;
        logic       typed;
        shifted_t   want;
    } date_row_t;

    // Fields run shift, weekday, year, month, day; results run overflow,
    // weekday, year, month, day. Rows without a typed result use the predictor.
    localparam date_row_t DIRECTED [23] = '{
        '{'{0, 5, 2024, 2, 15},       1'b1, '{0, 5, 2024, 2, 15}},
        '{'{0, 7, 0, 0, 1},           1'b1, '{0, 0, 0, 0, 1}},
        '{'{0, 3, 100, 15, 10},       1'b1, '{0, 3, 100, 11, 10}},
        '{'{-1, 0, 0, 0, 1},          1'b1, '{1, 6, 0, 11, 31}},
        '{'{1, 6, 16383, 11, 31},     1'b1, '{1, 0, 16383, 0, 1}},
        '{'{0, 7, 16383, 15, 31},     1'b1, '{0, 0, 16383, 11, 31}},
        '{'{1, 3, 2024, 1, 28},       1'b1, '{0, 4, 2024, 1, 29}},
        '{'{1, 0, 1900, 1, 28},       1'b1, '{0, 1, 1900, 2, 1}},
        '{'{1, 2, 2000, 1, 28},       1'b1, '{0, 3, 2000, 1, 29}},
        '{'{-1, 3, 2023, 2, 1},       1'b1, '{0, 2, 2023, 1, 28}},
        '{'{5, 4, 2021, 5, 10},       1'b1, '{0, 2, 2021, 5, 15}},
        '{'{-19, 2, 2022, 8, 20},     1'b1, '{0, 4, 2022, 8, 1}},
        '{'{1, 6, 2019, 10, 30},      1'b1, '{0, 0, 2019, 11, 1}},
        '{'{1, 5, 1999, 11, 31},      1'b1, '{0, 6, 2000, 0, 1}},
        '{'{32767, 6, 2000, 0, 1},    1'b0, '0},
        '{'{-32768, 5, 9999, 11, 31}, 1'b0, '0},
        '{'{32767, 1, 16383, 6, 15},  1'b0, '0},
        '{'{-32768, 4, 0, 6, 15},     1'b0, '0},
        '{'{-1, 2, 2020, 4, 0},       1'b0, '0},
        '{'{1, 2, 2020, 3, 31},       1'b0, '0},
        '{'{28, 0, 2023, 1, 0},       1'b0, '0},
        '{'{-40, 1, 500, 12, 5},      1'b0, '0},
        '{'{-32768, 7, 8191, 13, 31}, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    shifted_t pending_dates[$];
    int       mismatch_count = 0;
    int       results_seen = 0;
    int       hold_req = 0;
    int       quiet_cycles = 0;
    bit       calm_tx = 1'b0;

    calendar_date_shift uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic int days_in_month(input int mon, input int yr);
        bit leap;
        leap = ((yr % 4) == 0 && (yr % 100) != 0) || ((yr % 400) == 0);
        if (mon == MON_APR || mon == MON_JUN || mon == MON_SEP || mon == MON_NOV)
            return 30;
        if (mon == MON_FEB)
            return leap ? 29 : 28;
        return 31;
    endfunction

    function automatic shifted_t shift_date(input date_item_t it);
        int       d;
        int       m;
        int       y;
        int       x;
        int       w;
        shifted_t r;
        d = int'(it.day);
        m = (it.month > MON_DEC) ? int'(MON_DEC) : int'(it.month);
        y = int'(it.year);
        x = int'(it.shift);
        r.ovf = 1'b0;
        if (x > 0) begin
            if (x > days_in_month(m, y) - d) begin
                // Use up the rest of this month, then whole months.
                x -= days_in_month(m, y) - d;
                if (m != MON_DEC) m++; else begin m = MON_JAN; y++; end
                while (x > days_in_month(m, y)) begin
                    x -= days_in_month(m, y);
                    if (m != MON_DEC) m++; else begin m = MON_JAN; y++; end
                end
                d = x;
            end
            else begin
                d += x;
            end
        end
        else if (x < 0) begin
            x = -x;
            if (x >= d) begin
                // Backward steps count from the end of the previous month.
                x -= d;
                if (m != MON_JAN) m--; else begin m = MON_DEC; y--; end
                while (x >= days_in_month(m, y)) begin
                    x -= days_in_month(m, y);
                    if (m != MON_JAN) m--; else begin m = MON_DEC; y--; end
                end
                d = days_in_month(m, y) - x;
            end
            else begin
                d -= x;
            end
        end
        if (y < 0) begin
            y = 0;
            r.ovf = 1'b1;
        end
        else if (y > int'(YEAR_MAX)) begin
            y = int'(YEAR_MAX);
            r.ovf = 1'b1;
        end
        w = (int'(it.wday) + int'(it.shift)) % 7;
        if (w < 0)
            w += 7;
        r.day   = d[DAY_W-1:0];
        r.month = m[MONTH_W-1:0];
        r.year  = y[YEAR_W-1:0];
        r.wday  = w[WDAY_W-1:0];
        return r;
    endfunction

    task automatic send_date(input date_item_t it, input bit typed, input shifted_t want);
        if (!calm_tx) begin
            while ($urandom_range(99) < 10) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tdata  <= {6'b0, it};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_dates.push_back(typed ? want : shift_date(it));
    endtask

    // Result checking, and the ready pattern of the result side.
    always @(posedge clk) begin
        shifted_t got;
        shifted_t want;
        int       stall_left;
        int       hold_seen;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[26:0];
                results_seen++;
                if (pending_dates.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result %h", $time, m_tdata);
                end
                else begin
                    want = pending_dates.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        $display("%0t: mismatch: expected day %0d month %0d year %0d wd %0d ovf %0d, got day %0d month %0d year %0d wd %0d ovf %0d",
                                 $time, want.day, want.month, want.year, want.wday, want.ovf,
                                 got.day, got.month, got.year, got.wday, got.ovf);
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen  = hold_req;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= (results_seen >= 250 && results_seen < 330) ||
                            ($urandom_range(99) >= 10);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        date_item_t it;
        int         sel;
        int         mon;
        int         yr;
        int         len;
        int         amount;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_date(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);

        // Let the block drain completely before the random items.
        s_tvalid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm_tx = (n >= 200 && n < 300);
            // The result side holds off for a while; the sender keeps offering.
            if (n == 100)
                hold_req++;

            sel = $urandom_range(99);
            if (sel < 70)
                yr = $urandom_range(16383);
            else if (sel < 85)
                yr = $urandom_range(120);
            else
                yr = $urandom_range(16383, 16263);
            mon = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(11);
            len = days_in_month((mon > MON_DEC) ? int'(MON_DEC) : mon, yr);
            it.year  = yr[YEAR_W-1:0];
            it.month = mon[MONTH_W-1:0];
            it.day   = ($urandom_range(9) == 0) ? DAY_W'($urandom_range(31))
                                               : DAY_W'($urandom_range(len, 1));
            it.wday  = WDAY_W'($urandom_range(7));

            // Mostly short shifts keep the month walk brief; a few span the range.
            sel = $urandom_range(99);
            if (sel < 60)
                amount = $urandom_range(400);
            else if (sel < 85)
                amount = $urandom_range(4000);
            else if (sel < 95)
                amount = $urandom_range(32767);
            else
                amount = ($urandom_range(1) == 0) ? 32767 : 32768;
            if ($urandom_range(1) == 1 || amount == 32768)
                amount = -amount;
            it.shift = SHIFT_W'(amount);

            send_date(it, 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cds_pkg.sv
rtl/core/cds_ctrl.sv
rtl/core/cds_dpath.sv
rtl/core/calendar_date_shift.sv
sim/tb.sv
